// ===== rtl/core/dtq_pkg.sv =====
// dtq_pkg: codes, field widths and transaction payload types of the deadline timer queue.
// No dependencies; every other file but dtq_mem refers to it by scoped names.

package dtq_pkg;

    localparam int TIME_W    = 32;
    localparam int HANDLER_W = 16;
    localparam int HANDLE_W  = 4;
    localparam int COUNT_W   = 5;
    localparam int NEXT_W    = 33;

    // operation codes
    localparam logic [1:0] OP_SCHED_ABS = 2'd0;
    localparam logic [1:0] OP_SCHED_REL = 2'd1;
    localparam logic [1:0] OP_CANCEL    = 2'd2;
    localparam logic [1:0] OP_DELIVER   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SCHED   = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_PAST     = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    typedef struct packed {
        logic [1:0]           operation;
        logic [TIME_W-1:0]    time_value;
        logic [HANDLER_W-1:0] handler_id;
        logic [HANDLE_W-1:0]  event_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]           result_kind;
        logic [2:0]           status;
        logic [HANDLE_W-1:0]  handle;
        logic [HANDLER_W-1:0] fired_handler;
        logic [COUNT_W-1:0]   expired_count;
        logic [NEXT_W-1:0]    secs_to_next;
        logic                 next_valid;
        logic                 queue_empty;
        logic                 last;
    } t_rsp;

    // one table entry as seen by the min-search unit
    typedef struct packed {
        logic [TIME_W-1:0]    deadline;
        logic [TIME_W-1:0]    stamp;
        logic [HANDLER_W-1:0] handler;
        logic [HANDLE_W-1:0]  idx;
    } t_cand;

endpackage

// ===== rtl/core/dtq_if.sv =====
// dtq_if: valid/ready channel interfaces for request and response transactions.
// Depends on dtq_pkg for the payload types.

interface dtq_req_if;
    logic          valid;
    logic          ready;
    dtq_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtq_rsp_if;
    logic          valid;
    logic          ready;
    dtq_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dtq_mem.sv =====
// dtq_mem: slot table storage, one write port and one registered read port.
// No package dependency; widths come from parameters.

module dtq_mem #(
    parameter int DEPTH  = 16,
    parameter int AW     = 4,
    parameter int WIDTH  = 80
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dtq_scan.sv =====
// dtq_scan: min-search unit; keeps the earliest entry by deadline, then stamp.
// Depends on dtq_pkg (t_cand).

module dtq_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clr,
    input  logic           i_cand_vld,
    input  dtq_pkg::t_cand i_cand,
    output logic           o_found,
    output dtq_pkg::t_cand o_best
);

    logic           r_found, n_found;
    dtq_pkg::t_cand r_best,  n_best;
    logic           w_less;

    // ties on deadline fall back to the insertion stamp
    assign w_less = (i_cand.deadline < r_best.deadline) ||
                    ((i_cand.deadline == r_best.deadline) && (i_cand.stamp < r_best.stamp));

    always_comb begin
        n_found = r_found;
        n_best  = r_best;
        if (i_clr) begin
            n_found = 1'b0;
        end else if (i_cand_vld && (!r_found || w_less)) begin
            n_found = 1'b1;
            n_best  = i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_found = r_found;
    assign o_best  = r_best;

endmodule

// ===== rtl/core/deadline_timer_queue.sv =====
// Deadline timer queue: schedule answers from S_SCHED, cancel reads the slot in S_CRD and
// answers from S_CCHK, deliver runs a full slot scan per expired entry and one for the summary.
// One transaction is worked at a time; a new request is taken only in the idle state.
// Results leave through a one-deep output register, which may still hold a result while
// the next request is accepted. Reset (synchronous, active low) empties the table,
// zeroes current time and stamp counter; slot storage itself is not cleared.

module deadline_timer_queue #(
    parameter int CAPACITY     = 16,
    parameter int HANDLER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dtq_req_if.sink          i_req,
    dtq_rsp_if.source        o_rsp
);

    // handles are 4 bits wide, so at most 16 slots exist
    localparam int SLOTS = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW    = (HANDLER_BITS < dtq_pkg::HANDLER_W) ? HANDLER_BITS
                                                               : dtq_pkg::HANDLER_W;
    localparam int TW    = dtq_pkg::TIME_W;
    localparam int MW    = 2 * TW + HW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCHED  = 6'b000010,
        S_CRD    = 6'b000100,
        S_CCHK   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_DECIDE = 6'b100000
    } t_state;

    t_state          r_state;
    dtq_pkg::t_req   r_req;
    logic [TW-1:0]   r_now;
    logic [TW-1:0]   r_stamp_ctr;
    logic [SLOTS-1:0] r_valid;
    logic [AW:0]     r_idx;          // scan issue pointer, may reach SLOTS
    logic            r_pend;         // read data of r_ridx arrives this cycle
    logic [AW-1:0]   r_ridx;
    logic [dtq_pkg::COUNT_W-1:0] r_count;
    dtq_pkg::t_rsp   r_rsp, n_rsp;
    logic            r_out_vld;

    logic            w_accept;
    logic            w_out_free;
    logic            w_emit;
    logic [AW-1:0]   w_free_idx;
    logic            w_free_any;
    logic [TW:0]     w_sum;
    logic [TW-1:0]   w_sched_dl;
    logic [2:0]      w_sched_st;
    logic            w_sched_ok;
    logic [AW-1:0]   w_eh_idx;
    logic            w_eh_in_range;
    logic            w_cancel_hit;
    logic [AW-1:0]   w_raddr;
    logic [MW-1:0]   w_rdata;
    logic [MW-1:0]   w_wdata;
    logic            w_we;
    logic            w_scan_clr;
    logic            w_cand_vld;
    dtq_pkg::t_cand  w_cand;
    logic            w_found;
    dtq_pkg::t_cand  w_best;
    logic            w_expire;
    logic            w_scan_done;

    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_vld || o_rsp.ready;

    // lowest free slot
    always_comb begin
        w_free_idx = '0;
        w_free_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = AW'(i);
                w_free_any = 1'b1;
            end
        end
    end

    // schedule: absolute deadline or now + delay, checked in priority order
    assign w_sum      = {1'b0, r_now} + {1'b0, r_req.time_value};
    assign w_sched_dl = (r_req.operation == dtq_pkg::OP_SCHED_ABS) ? r_req.time_value
                                                                   : w_sum[TW-1:0];
    always_comb begin
        if (!w_free_any) begin
            w_sched_st = dtq_pkg::ST_FULL;
        end else if ((r_req.operation == dtq_pkg::OP_SCHED_ABS) &&
                     (r_req.time_value < r_now)) begin
            w_sched_st = dtq_pkg::ST_PAST;
        end else if ((r_req.operation == dtq_pkg::OP_SCHED_REL) && w_sum[TW]) begin
            w_sched_st = dtq_pkg::ST_OVERFLOW;
        end else begin
            w_sched_st = dtq_pkg::ST_OK;
        end
    end
    assign w_sched_ok = (w_sched_st == dtq_pkg::ST_OK);

    // cancel: slot must be in range, occupied, deadline equal and not already past
    assign w_eh_idx      = r_req.event_handle[AW-1:0];
    assign w_eh_in_range = (32'(r_req.event_handle) < SLOTS);
    assign w_cancel_hit  = w_eh_in_range && r_valid[w_eh_idx] &&
                           (w_rdata[MW-1 -: TW] == r_req.time_value) &&
                           (r_req.time_value >= r_now);

    // table storage
    assign w_raddr = (r_state == S_SCAN) ? r_idx[AW-1:0] : w_eh_idx;
    assign w_we    = (r_state == S_SCHED) && w_emit && w_sched_ok;
    assign w_wdata = {w_sched_dl, r_stamp_ctr, r_req.handler_id[HW-1:0]};

    dtq_mem #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .WIDTH (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_free_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // earliest-entry search, fed one slot per cycle from the read port
    assign w_cand.deadline = w_rdata[MW-1 -: TW];
    assign w_cand.stamp    = w_rdata[HW +: TW];
    assign w_cand.handler  = dtq_pkg::HANDLER_W'(w_rdata[HW-1:0]);
    assign w_cand.idx      = dtq_pkg::HANDLE_W'(r_ridx);
    assign w_cand_vld      = (r_state == S_SCAN) && r_pend && r_valid[r_ridx];

    assign w_expire    = w_found && (w_best.deadline < r_now);
    assign w_scan_clr  = (w_accept && (i_req.data.operation == dtq_pkg::OP_DELIVER)) ||
                         ((r_state == S_DECIDE) && w_emit && w_expire);
    assign w_scan_done = (r_idx == (AW+1)'(SLOTS)) && !r_pend;

    dtq_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (w_scan_clr),
        .i_cand_vld (w_cand_vld),
        .i_cand     (w_cand),
        .o_found    (w_found),
        .o_best     (w_best)
    );

    // result for the current state; emitted when the output register frees up
    always_comb begin
        n_rsp  = '0;
        w_emit = 1'b0;
        n_rsp.last = 1'b1;
        case (r_state)
            S_SCHED: begin
                w_emit           = w_out_free;
                n_rsp.result_kind = dtq_pkg::KIND_SCHED;
                n_rsp.status     = w_sched_st;
                n_rsp.handle     = w_sched_ok ? dtq_pkg::HANDLE_W'(w_free_idx) : '0;
            end
            S_CCHK: begin
                w_emit           = w_out_free;
                n_rsp.result_kind = dtq_pkg::KIND_CANCEL;
                n_rsp.status     = w_cancel_hit ? dtq_pkg::ST_OK : dtq_pkg::ST_IGNORED;
            end
            S_DECIDE: begin
                w_emit = w_out_free;
                if (w_expire) begin
                    n_rsp.result_kind   = dtq_pkg::KIND_EXPIRED;
                    n_rsp.handle        = w_best.idx;
                    n_rsp.fired_handler = w_best.handler;
                    n_rsp.last          = 1'b0;
                end else begin
                    n_rsp.result_kind   = dtq_pkg::KIND_SUMMARY;
                    n_rsp.expired_count = r_count;
                    n_rsp.next_valid    = w_found;
                    n_rsp.queue_empty   = !w_found;
                    n_rsp.secs_to_next  = w_found ?
                        ({1'b0, w_best.deadline - r_now} + dtq_pkg::NEXT_W'(1)) : '0;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_stamp_ctr <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_req.data.operation)
                            dtq_pkg::OP_CANCEL: begin
                                r_state <= S_CRD;
                            end
                            dtq_pkg::OP_DELIVER: begin
                                r_now   <= i_req.data.time_value;
                                r_count <= '0;
                                r_idx   <= '0;
                                r_pend  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_SCHED;
                            end
                        endcase
                    end
                end
                S_SCHED: begin
                    if (w_emit) begin
                        if (w_sched_ok) begin
                            r_valid[w_free_idx] <= 1'b1;
                            r_stamp_ctr         <= r_stamp_ctr + TW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_CRD: begin
                    r_state <= S_CCHK;     // read of the named slot in flight
                end
                S_CCHK: begin
                    if (w_emit) begin
                        if (w_cancel_hit) begin
                            r_valid[w_eh_idx] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_idx < (AW+1)'(SLOTS)) begin
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + (AW+1)'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (w_scan_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_emit) begin
                        if (w_expire) begin
                            // retire the earliest entry and search again
                            r_valid[w_best.idx[AW-1:0]] <= 1'b0;
                            r_count <= r_count + dtq_pkg::COUNT_W'(1);
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // slot index that the read data belongs to
    always_ff @(posedge i_clk) begin
        r_ridx <= r_idx[AW-1:0];
        if (w_accept) begin
            r_req <= i_req.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_rsp;

    // a successful schedule occupies its slot
    a_sched_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHED && w_emit && w_sched_ok) |=> r_valid[$past(w_free_idx)])
        else $error("scheduled slot not marked valid");

    // the entry picked by the search is still occupied when acted upon
    a_best_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_found) |-> r_valid[w_best.idx[AW-1:0]])
        else $error("earliest entry refers to a free slot");

    // scan pointer stays within the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= (AW+1)'(SLOTS)))
        else $error("scan pointer past table end");

    // an expired entry is never reported twice in one deliver
    a_expire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_emit && w_expire) |=>
            !r_valid[$past(w_best.idx[AW-1:0])])
        else $error("expired entry left in table");

endmodule

// ===== bench/deadline_timer_queue_checker.sv =====
// Checker for the deadline timer queue: watches both channels, keeps its own copy of the
// timeout table, predicts every result transaction and compares it field by field.
// Depends on dtq_pkg for codes and payload types.
`timescale 1ns / 1ps

module deadline_timer_queue_checker #(
    parameter int CAPACITY     = 16,
    parameter int HANDLER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  dtq_pkg::t_req        i_req,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  dtq_pkg::t_rsp        i_rsp,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output logic [15:0]          o_live,
    output logic [15:0][31:0]    o_deadline,
    output logic [31:0]          o_now
);

    localparam int SLOTS = (CAPACITY < 16) ? CAPACITY : 16;
    localparam logic [31:0] HANDLER_MASK =
        (HANDLER_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << HANDLER_BITS) - 64'd1);

    // shadow of the timeout table
    logic [15:0]       live;
    logic [15:0][31:0] deadline_tab;
    logic [15:0][15:0] handler_tab;
    logic [15:0][31:0] stamp_tab;
    logic [31:0]       now_t;
    logic [31:0]       insert_cnt;

    dtq_pkg::t_rsp awaited_rsp[$];
    int   error_count = 0;
    int   checked     = 0;

    assign o_errors  = error_count;
    assign o_results = checked;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 50)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h expected %h",
                                      checked, name, got, want));
    endtask

    // earliest live entry by deadline, then stamp; -1 when table is empty
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
                if (best < 0 || deadline_tab[i] < deadline_tab[best] ||
                    (deadline_tab[i] == deadline_tab[best] &&
                     stamp_tab[i] < stamp_tab[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    task automatic table_reset();
        live         = '0;
        deadline_tab = '0;
        handler_tab  = '0;
        stamp_tab    = '0;
        now_t        = '0;
        insert_cnt   = '0;
        awaited_rsp.delete();
    endtask

    task automatic predict_schedule(input logic [31:0] deadline, input logic [15:0] hid,
                                    input logic [2:0] status_in);
        int            slot;
        logic [2:0]    st;
        dtq_pkg::t_rsp r;
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (!live[i] && slot < 0) slot = i;
        st = status_in;
        if (slot < 0) st = dtq_pkg::ST_FULL;    // full table wins over every other reject
        r = '0;
        r.result_kind = dtq_pkg::KIND_SCHED;
        r.last        = 1'b1;
        if (st != dtq_pkg::ST_OK) begin
            r.status = st;
        end else begin
            live[slot]         = 1'b1;
            deadline_tab[slot] = deadline;
            handler_tab[slot]  = 16'(32'(hid) & HANDLER_MASK);
            stamp_tab[slot]    = insert_cnt;
            insert_cnt         = insert_cnt + 32'd1;
            r.handle           = 4'(slot);
        end
        awaited_rsp.push_back(r);
    endtask

    task automatic predict_request(input dtq_pkg::t_req item);
        logic [32:0]   sum;
        dtq_pkg::t_rsp r;
        int            e;
        int            k;
        case (item.operation)
            dtq_pkg::OP_SCHED_ABS: begin
                predict_schedule(item.time_value, item.handler_id,
                                 (item.time_value < now_t) ? dtq_pkg::ST_PAST
                                                           : dtq_pkg::ST_OK);
            end
            dtq_pkg::OP_SCHED_REL: begin
                sum = {1'b0, now_t} + {1'b0, item.time_value};
                predict_schedule(sum[31:0], item.handler_id,
                                 sum[32] ? dtq_pkg::ST_OVERFLOW : dtq_pkg::ST_OK);
            end
            dtq_pkg::OP_CANCEL: begin
                r = '0;
                r.result_kind = dtq_pkg::KIND_CANCEL;
                r.status      = dtq_pkg::ST_IGNORED;
                r.last        = 1'b1;
                if (int'(item.event_handle) < SLOTS && live[item.event_handle] &&
                    deadline_tab[item.event_handle] == item.time_value &&
                    item.time_value >= now_t) begin
                    live[item.event_handle] = 1'b0;
                    r.status = dtq_pkg::ST_OK;
                end
                awaited_rsp.push_back(r);
            end
            default: begin
                // deliver: expire strictly-past entries in deadline, then stamp order
                now_t = item.time_value;
                k = 0;
                e = earliest_slot();
                while (e >= 0 && deadline_tab[e] < now_t) begin
                    r = '0;
                    r.result_kind   = dtq_pkg::KIND_EXPIRED;
                    r.handle        = 4'(e);
                    r.fired_handler = handler_tab[e];
                    awaited_rsp.push_back(r);
                    live[e] = 1'b0;
                    k++;
                    e = earliest_slot();
                end
                r = '0;
                r.result_kind   = dtq_pkg::KIND_SUMMARY;
                r.expired_count = 5'(k);
                r.last          = 1'b1;
                if (e < 0) begin
                    r.queue_empty = 1'b1;
                end else begin
                    r.secs_to_next = {1'b0, deadline_tab[e] - now_t} + 33'd1;
                    r.next_valid   = 1'b1;
                end
                awaited_rsp.push_back(r);
            end
        endcase
    endtask

    task automatic check_rsp(input dtq_pkg::t_rsp got);
        dtq_pkg::t_rsp want;
        if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
        end else begin
            want = awaited_rsp.pop_front();
            check_field("result_kind",   got.result_kind,   want.result_kind);
            check_field("status",        got.status,        want.status);
            check_field("handle",        got.handle,        want.handle);
            check_field("fired_handler", got.fired_handler, want.fired_handler);
            check_field("expired_count", got.expired_count, want.expired_count);
            check_field("secs_to_next",  got.secs_to_next,  want.secs_to_next);
            check_field("next_valid",    got.next_valid,    want.next_valid);
            check_field("queue_empty",   got.queue_empty,   want.queue_empty);
            check_field("last",          got.last,          want.last);
            checked++;
        end
    endtask

    // predict before compare, so a same-edge request never overtakes older results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_reset();
        end else begin
            if (i_req_valid && i_req_ready) predict_request(i_req);
            if (i_rsp_valid && i_rsp_ready) check_rsp(i_rsp);
        end
        o_pending  <= awaited_rsp.size();
        o_live     <= live;
        o_deadline <= deadline_tab;
        o_now      <= now_t;
    end

endmodule

// ===== bench/deadline_timer_queue_test.sv =====
// Testbench top for the deadline timer queue: clock, reset, request stimulus and random
// backpressure; the checker beside the block predicts and compares every result.
// Depends on dtq_pkg, dtq_if, deadline_timer_queue and deadline_timer_queue_checker.
`timescale 1ns / 1ps

module deadline_timer_queue_test;

    localparam int CAPACITY     = 16;
    localparam int HANDLER_BITS = 16;
    localparam int RANDOM_ITEMS = 500;
    // worst case: 17 results, each after a full slot scan and stretched by stalls, per request
    localparam int CYCLE_LIMIT  = 2_000_000;
    // quiet time after the last result, enough for full slot scans
    localparam int DRAIN_CYCLES = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;

    // no idling on either side while set
    logic calm = 1'b0;

    int n_sched  = 0;
    int n_cancel = 0;
    int n_deliver = 0;

    dtq_req_if req_ch ();
    dtq_rsp_if rsp_ch ();

    int                chk_errors;
    int                chk_pending;
    int                chk_results;
    logic [15:0]       chk_live;
    logic [15:0][31:0] chk_deadline;
    logic [31:0]       chk_now;

    deadline_timer_queue #(
        .CAPACITY     (CAPACITY),
        .HANDLER_BITS (HANDLER_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    deadline_timer_queue_checker #(
        .CAPACITY     (CAPACITY),
        .HANDLER_BITS (HANDLER_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req       (req_ch.data),
        .i_rsp_valid (rsp_ch.valid),
        .i_rsp_ready (rsp_ch.ready),
        .i_rsp       (rsp_ch.data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_results   (chk_results),
        .o_live      (chk_live),
        .o_deadline  (chk_deadline),
        .o_now       (chk_now)
    );

    always #4 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls about a third of the time, never during the calm stretch
    always @(posedge i_clk) begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 34);
    end

    function automatic dtq_pkg::t_req req_of(input logic [1:0] op, input logic [31:0] tv,
                                             input logic [15:0] hid, input logic [3:0] eh);
        dtq_pkg::t_req item;
        item.operation    = op;
        item.time_value   = tv;
        item.handler_id   = hid;
        item.event_handle = eh;
        return item;
    endfunction

    // Offer one request transaction and hold it until accepted. Valid stays high on
    // return so back-to-back transactions never drop and re-raise it in one step.
    task automatic send_req(input dtq_pkg::t_req item);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 34) gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.data  <= item;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        case (item.operation)
            dtq_pkg::OP_SCHED_ABS, dtq_pkg::OP_SCHED_REL: n_sched++;
            dtq_pkg::OP_CANCEL:                           n_cancel++;
            default:                                      n_deliver++;
        endcase
    endtask

    // Sender stops until every predicted result has been taken.
    // The checker's pending count is registered, so wait past the next edge before looking.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    // Random request, mostly aimed near the current time so entries expire and
    // cancels hit live slots; the rest is noise over the full field ranges.
    // The checker's table view may lag by the transaction just accepted.
    function automatic dtq_pkg::t_req random_req();
        dtq_pkg::t_req item;
        int            pick;
        int            sub;
        int            live_idx[$];
        logic [31:0]   now_t;
        now_t = chk_now;
        item.operation    = dtq_pkg::OP_SCHED_ABS;
        item.time_value   = $urandom;
        item.handler_id   = 16'($urandom_range(0, 65535));
        item.event_handle = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (pick < 50) begin
            if (sub < 60) begin
                item.time_value = now_t + 32'($urandom_range(1, 300));
            end else if (sub < 75) begin
                item.operation  = dtq_pkg::OP_SCHED_REL;
                item.time_value = 32'($urandom_range(0, 300));
            end else if (sub < 85) begin
                item.time_value = $urandom;
            end else if (sub < 93) begin
                item.time_value = now_t - 32'($urandom_range(1, 50));
            end else begin
                // straddle the 32-bit end: exact fit or overflow
                item.operation  = dtq_pkg::OP_SCHED_REL;
                item.time_value = ~now_t + 32'($urandom_range(0, 3));
            end
        end else if (pick < 70) begin
            item.operation = dtq_pkg::OP_CANCEL;
            for (int i = 0; i < 16; i++)
                if (chk_live[i]) live_idx.push_back(i);
            if (live_idx.size() > 0 && sub < 75) begin
                item.event_handle = 4'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
                item.time_value   = chk_deadline[item.event_handle];
            end else if (sub < 88) begin
                item.time_value = chk_deadline[item.event_handle] + 32'd1;
            end
        end else begin
            item.operation = dtq_pkg::OP_DELIVER;
            if (sub < 70)
                item.time_value = now_t + 32'($urandom_range(0, 150));
            else if (sub < 80)
                item.time_value = now_t - 32'($urandom_range(0, 100));
            else if (sub < 90)
                item.time_value = $urandom;
            else
                item.time_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        return item;
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        send_req(req_of(dtq_pkg::OP_SCHED_ABS, 32'h10, 16'hFFFF, 4'd0));   // slot 0
        send_req(req_of(dtq_pkg::OP_SCHED_REL, 32'h0, 16'h0000, 4'd0));    // zero delay, slot 1
        send_req(req_of(dtq_pkg::OP_CANCEL, 32'h0, 16'h0, 4'd1));          // good cancel
        send_req(req_of(dtq_pkg::OP_CANCEL, 32'h0, 16'h0, 4'd1));          // slot no longer live
        send_req(req_of(dtq_pkg::OP_DELIVER, 32'h20, 16'h0, 4'd0));        // fires slot 0
        send_req(req_of(dtq_pkg::OP_SCHED_ABS, 32'h1F, 16'h1234, 4'd0));   // deadline past
        send_req(req_of(dtq_pkg::OP_SCHED_ABS, 32'hFFFF_FFFF, 16'hAAAA, 4'd15));
        send_req(req_of(dtq_pkg::OP_SCHED_REL, 32'hFFFF_FFFF, 16'h0, 4'd0)); // overflow
        send_req(req_of(dtq_pkg::OP_SCHED_REL, 32'hFFFF_FFDF, 16'h5555, 4'd0)); // max, tie
        send_req(req_of(dtq_pkg::OP_CANCEL, 32'hFFFF_FFFE, 16'h0, 4'd0));  // deadline mismatch
        send_req(req_of(dtq_pkg::OP_DELIVER, 32'h0, 16'hFFFF, 4'hF));      // time backwards
        // slot reuse with an equal deadline: later stamp must fire after the older entry
        send_req(req_of(dtq_pkg::OP_SCHED_ABS, 32'h40, 16'h0001, 4'd0));   // slot 2
        send_req(req_of(dtq_pkg::OP_SCHED_ABS, 32'h40, 16'h0002, 4'd0));   // slot 3
        send_req(req_of(dtq_pkg::OP_CANCEL, 32'h40, 16'h0, 4'd2));
        send_req(req_of(dtq_pkg::OP_SCHED_ABS, 32'h40, 16'h0003, 4'd0));   // reuses slot 2
        send_req(req_of(dtq_pkg::OP_DELIVER, 32'h41, 16'h0, 4'd0));
        send_req(req_of(dtq_pkg::OP_CANCEL, 32'hFFFF_FFFF, 16'h0, 4'd0));  // drop one max entry
        // fill the table, then one more is rejected as full
        for (int i = 0; i < 16; i++)
            send_req(req_of(dtq_pkg::OP_SCHED_ABS, 32'h100 + 32'(i),
                            16'(16'hF0F0 ^ i), 4'(i)));
        send_req(req_of(dtq_pkg::OP_DELIVER, 32'hFFFF_FFFF, 16'h0, 4'd0)); // mass expiry
        wait_for_drain();

        // --- random part ---
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 200 && n < 300);
            if (n == 150 || n == 400) wait_for_drain();
            send_req(random_req());
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d schedule, %0d cancel, %0d deliver; %0d results checked",
                 n_sched + n_cancel + n_deliver, n_sched, n_cancel, n_deliver, chk_results);
        $display("Mismatches: %0d, results still awaited: %0d", chk_errors, chk_pending);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dtq_pkg.sv
rtl/core/dtq_if.sv
rtl/core/dtq_mem.sv
rtl/core/dtq_scan.sv
rtl/core/deadline_timer_queue.sv
bench/deadline_timer_queue_checker.sv
bench/deadline_timer_queue_test.sv
